// ===== design/ascm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ascm_pkg;

  // Field widths of one request and one result
  localparam int REQ_W     = 32;
  localparam int ALIGNED_W = 33;
  localparam int CLASS_W   = 8;
  localparam int BLOCKS_W  = 10;
  localparam int PAGES_W   = 20;

  // Page size and the largest request served from size classes
  localparam int PAGE_BITS       = 13;
  localparam int SMALL_MAX_BYTES = 262144;

  // Packed result word, lowest field first
  localparam int TDATA_OUT_W = 72;
  localparam int TUSER_OUT_W = 2;
  localparam int USER_LARGE  = 0;
  localparam int USER_ERROR  = 1;

  // Size tiers
  localparam int TIER_COUNT = 5;
  localparam int TIER_W     = 3;
  localparam int SHIFT_W    = 5;

  localparam logic [REQ_W-1:0] TIER_UPPER [TIER_COUNT] = '{
    32'd128, 32'd1024, 32'd8192, 32'd65536, 32'd262144
  };
  localparam logic [SHIFT_W-1:0] TIER_SHIFT [TIER_COUNT] = '{
    5'd3, 5'd4, 5'd7, 5'd10, 5'd13
  };
  localparam logic [CLASS_W-1:0] TIER_BASE [TIER_COUNT] = '{
    8'd0, 8'd16, 8'd72, 8'd128, 8'd184
  };

  // Multiple index within a tier: aligned >> shift, 1..64
  localparam int MULT_W  = 7;
  localparam int RECIP_W = 19;
  localparam int PROD_W  = BLOCKS_W + RECIP_W;

  localparam logic [BLOCKS_W-1:0] BLOCKS_MIN     = 10'd2;
  localparam logic [BLOCKS_W-1:0] BLOCKS_MAX     = 10'd512;
  localparam logic [PAGES_W-1:0]  PAGE_FIELD_MAX = 20'hFFFFF;

  // floor(SMALL_MAX_BYTES / (i + 1)); the span block count is this value
  // shifted right by the tier alignment shift, then clamped to its bounds
  localparam logic [RECIP_W-1:0] RECIP_TABLE [64] = '{
    19'(SMALL_MAX_BYTES / 1),  19'(SMALL_MAX_BYTES / 2),
    19'(SMALL_MAX_BYTES / 3),  19'(SMALL_MAX_BYTES / 4),
    19'(SMALL_MAX_BYTES / 5),  19'(SMALL_MAX_BYTES / 6),
    19'(SMALL_MAX_BYTES / 7),  19'(SMALL_MAX_BYTES / 8),
    19'(SMALL_MAX_BYTES / 9),  19'(SMALL_MAX_BYTES / 10),
    19'(SMALL_MAX_BYTES / 11), 19'(SMALL_MAX_BYTES / 12),
    19'(SMALL_MAX_BYTES / 13), 19'(SMALL_MAX_BYTES / 14),
    19'(SMALL_MAX_BYTES / 15), 19'(SMALL_MAX_BYTES / 16),
    19'(SMALL_MAX_BYTES / 17), 19'(SMALL_MAX_BYTES / 18),
    19'(SMALL_MAX_BYTES / 19), 19'(SMALL_MAX_BYTES / 20),
    19'(SMALL_MAX_BYTES / 21), 19'(SMALL_MAX_BYTES / 22),
    19'(SMALL_MAX_BYTES / 23), 19'(SMALL_MAX_BYTES / 24),
    19'(SMALL_MAX_BYTES / 25), 19'(SMALL_MAX_BYTES / 26),
    19'(SMALL_MAX_BYTES / 27), 19'(SMALL_MAX_BYTES / 28),
    19'(SMALL_MAX_BYTES / 29), 19'(SMALL_MAX_BYTES / 30),
    19'(SMALL_MAX_BYTES / 31), 19'(SMALL_MAX_BYTES / 32),
    19'(SMALL_MAX_BYTES / 33), 19'(SMALL_MAX_BYTES / 34),
    19'(SMALL_MAX_BYTES / 35), 19'(SMALL_MAX_BYTES / 36),
    19'(SMALL_MAX_BYTES / 37), 19'(SMALL_MAX_BYTES / 38),
    19'(SMALL_MAX_BYTES / 39), 19'(SMALL_MAX_BYTES / 40),
    19'(SMALL_MAX_BYTES / 41), 19'(SMALL_MAX_BYTES / 42),
    19'(SMALL_MAX_BYTES / 43), 19'(SMALL_MAX_BYTES / 44),
    19'(SMALL_MAX_BYTES / 45), 19'(SMALL_MAX_BYTES / 46),
    19'(SMALL_MAX_BYTES / 47), 19'(SMALL_MAX_BYTES / 48),
    19'(SMALL_MAX_BYTES / 49), 19'(SMALL_MAX_BYTES / 50),
    19'(SMALL_MAX_BYTES / 51), 19'(SMALL_MAX_BYTES / 52),
    19'(SMALL_MAX_BYTES / 53), 19'(SMALL_MAX_BYTES / 54),
    19'(SMALL_MAX_BYTES / 55), 19'(SMALL_MAX_BYTES / 56),
    19'(SMALL_MAX_BYTES / 57), 19'(SMALL_MAX_BYTES / 58),
    19'(SMALL_MAX_BYTES / 59), 19'(SMALL_MAX_BYTES / 60),
    19'(SMALL_MAX_BYTES / 61), 19'(SMALL_MAX_BYTES / 62),
    19'(SMALL_MAX_BYTES / 63), 19'(SMALL_MAX_BYTES / 64)
  };

  // Load enables for the back stages
  typedef struct packed {
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== design/ascm_span.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Back half of the pipeline: class index, span block count, span page count
module ascm_span (
  input  wire                                  clk,
  input  ascm_pkg::stage_en_t                  en,
  input  wire  [ascm_pkg::ALIGNED_W-1:0]       aligned_i,
  input  wire  [ascm_pkg::TIER_W-1:0]          tier_i,
  input  wire  [ascm_pkg::SHIFT_W-1:0]         shift_i,
  input  wire                                  large_i,
  input  wire                                  error_i,
  output logic [ascm_pkg::ALIGNED_W-1:0]       aligned_o,
  output logic [ascm_pkg::CLASS_W-1:0]         class_o,
  output logic                                 large_o,
  output logic [ascm_pkg::BLOCKS_W-1:0]        blocks_o,
  output logic [ascm_pkg::PAGES_W-1:0]         pages_o,
  output logic                                 error_o
);

  // Stage 3 registers
  logic [ascm_pkg::ALIGNED_W-1:0] s3_aligned_r, s3_aligned_nxt;
  logic [ascm_pkg::CLASS_W-1:0]   s3_class_r, s3_class_nxt;
  logic [ascm_pkg::BLOCKS_W-1:0]  s3_blocks_r, s3_blocks_nxt;
  logic [ascm_pkg::PAGES_W-1:0]   s3_lpages_r, s3_lpages_nxt;
  logic                           s3_large_r, s3_error_r;

  // Stage 4 registers
  logic [ascm_pkg::ALIGNED_W-1:0] s4_aligned_r, s4_aligned_nxt;
  logic [ascm_pkg::CLASS_W-1:0]   s4_class_r, s4_class_nxt;
  logic [ascm_pkg::BLOCKS_W-1:0]  s4_blocks_r, s4_blocks_nxt;
  logic [ascm_pkg::PAGES_W-1:0]   s4_pages_r, s4_pages_nxt;
  logic                           s4_large_r, s4_error_r;

  logic [ascm_pkg::ALIGNED_W-1:0] mult_full;
  logic [ascm_pkg::MULT_W-1:0]    mult;
  logic [5:0]                     recip_idx;
  logic [ascm_pkg::RECIP_W-1:0]   blk_raw;
  logic [ascm_pkg::CLASS_W-1:0]   class_off;
  logic [ascm_pkg::ALIGNED_W-1:0] lpages_full;
  logic [ascm_pkg::PROD_W-1:0]    prod;
  logic [ascm_pkg::PROD_W-1:0]    span_pages;

  // Stage 3: multiple within the tier, class index, clamped block count
  always_comb begin
    mult_full = aligned_i >> shift_i;
    mult      = mult_full[ascm_pkg::MULT_W-1:0];
    recip_idx = 6'(mult - 7'd1);
    blk_raw   = ascm_pkg::RECIP_TABLE[recip_idx] >> shift_i;
    class_off = (tier_i == '0) ? 8'd1 : 8'd9;
    s3_class_nxt = ascm_pkg::TIER_BASE[tier_i] + {1'b0, mult} - class_off;
    if (blk_raw > 19'(ascm_pkg::BLOCKS_MAX)) begin
      s3_blocks_nxt = ascm_pkg::BLOCKS_MAX;
    end else if (blk_raw < 19'(ascm_pkg::BLOCKS_MIN)) begin
      s3_blocks_nxt = ascm_pkg::BLOCKS_MIN;
    end else begin
      s3_blocks_nxt = blk_raw[ascm_pkg::BLOCKS_W-1:0];
    end
    // Direct page count for a large request, saturated to the field
    lpages_full = aligned_i >> ascm_pkg::PAGE_BITS;
    if (lpages_full > 33'(ascm_pkg::PAGE_FIELD_MAX)) begin
      s3_lpages_nxt = ascm_pkg::PAGE_FIELD_MAX;
    end else begin
      s3_lpages_nxt = lpages_full[ascm_pkg::PAGES_W-1:0];
    end
    s3_aligned_nxt = aligned_i;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_aligned_r <= s3_aligned_nxt;
      s3_class_r   <= s3_class_nxt;
      s3_blocks_r  <= s3_blocks_nxt;
      s3_lpages_r  <= s3_lpages_nxt;
      s3_large_r   <= large_i;
      s3_error_r   <= error_i;
    end
  end

  // Stage 4: span bytes to pages, then zero the fields that do not apply
  always_comb begin
    prod       = ascm_pkg::PROD_W'(s3_blocks_r) *
                 ascm_pkg::PROD_W'(s3_aligned_r[ascm_pkg::RECIP_W-1:0]);
    span_pages = prod >> ascm_pkg::PAGE_BITS;
    s4_aligned_nxt = s3_aligned_r;
    s4_class_nxt   = s3_class_r;
    s4_blocks_nxt  = s3_blocks_r;
    if (span_pages == '0) begin
      s4_pages_nxt = 20'd1;
    end else begin
      s4_pages_nxt = span_pages[ascm_pkg::PAGES_W-1:0];
    end
    if (s3_error_r) begin
      s4_aligned_nxt = '0;
      s4_class_nxt   = '0;
      s4_blocks_nxt  = '0;
      s4_pages_nxt   = '0;
    end else if (s3_large_r) begin
      s4_class_nxt  = '0;
      s4_blocks_nxt = '0;
      s4_pages_nxt  = s3_lpages_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_aligned_r <= s4_aligned_nxt;
      s4_class_r   <= s4_class_nxt;
      s4_blocks_r  <= s4_blocks_nxt;
      s4_pages_r   <= s4_pages_nxt;
      s4_large_r   <= s3_large_r & ~s3_error_r;
      s4_error_r   <= s3_error_r;
    end
  end

  assign aligned_o = s4_aligned_r;
  assign class_o   = s4_class_r;
  assign large_o   = s4_large_r;
  assign blocks_o  = s4_blocks_r;
  assign pages_o   = s4_pages_r;
  assign error_o   = s4_error_r;

endmodule

`default_nettype wire

// ===== design/alloc_size_class_mapper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Allocation size-class mapper.
// The in_ channel carries one requested size in bytes per item. The out_
// channel returns one result item per request: the size rounded up by its
// tier, or to whole pages when large, the size class index, the span block
// count and span page count for a small request, or the direct page count
// for a large one. Zero size is flagged in out_tuser and every other field
// is then zero. Four register stages (tier select, round-up add, reciprocal
// table and clamp, block-times-size multiply) lie between an accepted
// request and its result. One item per cycle is taken while out_tready does
// not hold the pipeline.
// Each stage loads when it is empty or the stage after it moves, so a
// stalled out_tready holds the last result and the pipeline fills behind
// it; in_tready drops only once all four stages hold items.
// Reset clears the stage valid bits; no item is in flight afterwards and
// there is no configuration and no state beyond the pipeline.
module alloc_size_class_mapper_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // [31:0] request_size
  input  wire  [ascm_pkg::REQ_W-1:0]           in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [32:0] aligned_size, [40:33] class_index, [50:41] block_count,
  // [70:51] page_count, [71] zero pad
  output logic [ascm_pkg::TDATA_OUT_W-1:0]     out_tdata,
  // [0] is_large, [1] size_error
  output logic [ascm_pkg::TUSER_OUT_W-1:0]     out_tuser
);

  // Stage valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  ascm_pkg::stage_en_t en;

  // Stage 1 payload
  logic [ascm_pkg::REQ_W-1:0]   s1_size_r;
  logic [ascm_pkg::TIER_W-1:0]  s1_tier_r, s1_tier_nxt;
  logic                         s1_large_r, s1_large_nxt;
  logic                         s1_error_r, s1_error_nxt;

  // Stage 2 payload
  logic [ascm_pkg::ALIGNED_W-1:0] s2_aligned_r, s2_aligned_nxt;
  logic [ascm_pkg::TIER_W-1:0]    s2_tier_r;
  logic [ascm_pkg::SHIFT_W-1:0]   s2_shift_r, s2_shift_nxt;
  logic                           s2_large_r, s2_error_r;
  logic [ascm_pkg::ALIGNED_W-1:0] s2_mask;

  // Result fields
  logic [ascm_pkg::ALIGNED_W-1:0] res_aligned;
  logic [ascm_pkg::CLASS_W-1:0]   res_class;
  logic                           res_large;
  logic [ascm_pkg::BLOCKS_W-1:0]  res_blocks;
  logic [ascm_pkg::PAGES_W-1:0]   res_pages;
  logic                           res_error;

  // Advance a stage when it is empty or its contents move on
  always_comb begin
    rdy4 = !v4_r || out_tready;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    v1_nxt = rdy1 ? in_tvalid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
    en.s3 = rdy3;
    en.s4 = rdy4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Stage 1: classify the request and pick its tier
  always_comb begin
    s1_error_nxt = (in_tdata == '0);
    s1_large_nxt = (in_tdata > 32'(ascm_pkg::SMALL_MAX_BYTES));
    s1_tier_nxt  = 3'(ascm_pkg::TIER_COUNT - 1);
    for (int i = ascm_pkg::TIER_COUNT - 1; i >= 0; i--) begin
      if (in_tdata <= ascm_pkg::TIER_UPPER[i]) begin
        s1_tier_nxt = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_size_r  <= in_tdata;
      s1_tier_r  <= s1_tier_nxt;
      s1_large_r <= s1_large_nxt;
      s1_error_r <= s1_error_nxt;
    end
  end

  // Stage 2: round up to the tier alignment, or to whole pages when large
  always_comb begin
    s2_shift_nxt = s1_large_r ? 5'(ascm_pkg::PAGE_BITS) : ascm_pkg::TIER_SHIFT[s1_tier_r];
    s2_mask      = (33'd1 << s2_shift_nxt) - 33'd1;
    s2_aligned_nxt = ({1'b0, s1_size_r} + s2_mask) & ~s2_mask;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_aligned_r <= s2_aligned_nxt;
      s2_tier_r    <= s1_tier_r;
      s2_shift_r   <= s2_shift_nxt;
      s2_large_r   <= s1_large_r;
      s2_error_r   <= s1_error_r;
    end
  end

  // Stages 3 and 4
  ascm_span u_span (
    .clk       (clk),
    .en        (en),
    .aligned_i (s2_aligned_r),
    .tier_i    (s2_tier_r),
    .shift_i   (s2_shift_r),
    .large_i   (s2_large_r),
    .error_i   (s2_error_r),
    .aligned_o (res_aligned),
    .class_o   (res_class),
    .large_o   (res_large),
    .blocks_o  (res_blocks),
    .pages_o   (res_pages),
    .error_o   (res_error)
  );

  // Pack the result item
  assign in_tready  = rdy1;
  assign out_tvalid = v4_r;
  assign out_tdata  = {1'b0, res_pages, res_blocks, res_class, res_aligned};
  assign out_tuser  = {res_error, res_large};

  // Checks on the result fields and the ready chain
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[ascm_pkg::USER_ERROR] |-> out_tdata == '0)
    else $error("zero-size result carries nonzero fields");

  a_large_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[ascm_pkg::USER_LARGE] |-> out_tdata[50:33] == '0)
    else $error("large result carries class or block count");

  a_small_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == '0 |->
      res_blocks >= ascm_pkg::BLOCKS_MIN && res_blocks <= ascm_pkg::BLOCKS_MAX &&
      res_pages != '0)
    else $error("small result span out of range");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[ascm_pkg::USER_ERROR] && out_tuser[ascm_pkg::USER_LARGE]))
    else $error("result flagged both large and zero size");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

`default_nettype wire
